### rtl/float32_exp_table_poly_defines.svh
// ----------------------------------------------------------------------------
// float32_exp_table_poly assertion macros
// shared concurrent assertion forms, clocked on clk
// ----------------------------------------------------------------------------
`ifndef FLOAT32_EXP_TABLE_POLY_DEFINES_SVH
`define FLOAT32_EXP_TABLE_POLY_DEFINES_SVH

// checked only while out of reset
`define FEXP_ASSERT(name, prop, msg) \
name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define FEXP_ASSERT_ALWAYS(name, prop, msg) \
name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/fexp_pkg.sv
// ----------------------------------------------------------------------------
// fexp_pkg
// types, constants and arithmetic helpers of the float32 exponential
// ----------------------------------------------------------------------------
package fexp_pkg;

	typedef struct packed {
		logic [31:0] x_bits;
		logic        last_in;
	} item_t;

	typedef struct packed {
		logic [31:0] result_bits;
		logic        last_out;
	} result_t;

	// values that ride along the fma chain
	typedef struct packed {
		logic [31:0] x;
		logic [31:0] v;
		logic [31:0] t;
		logic [31:0] l;
		logic [31:0] sn;
		logic [31:0] so;
		logic [31:0] spv;
		logic        sp;
		logic        last;
	} side_t;

	localparam int unsigned NUM_FMA = 10;

	localparam logic [31:0] MAGIC_BIAS   = 32'h4B40_0000;
	localparam logic [31:0] NEG_MAGIC    = 32'hCB40_0000;
	localparam logic [31:0] LOG2E_X16    = 32'h41B8_AA3B;
	localparam logic [31:0] LN2_O16_HI   = 32'hBD31_7218;
	localparam logic [31:0] LN2_O16_LO   = 32'h2F02_E308;
	localparam logic [31:0] POLY_C2      = 32'h3F00_010F;
	localparam logic [31:0] POLY_C3      = 32'h3E2A_AACD;
	localparam logic [31:0] FP_ONE       = 32'h3F80_0000;
	localparam logic [31:0] FP_ZERO      = 32'h0000_0000;
	localparam logic [31:0] FP_INF       = 32'h7F80_0000;
	localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;
	localparam logic [30:0] ZERO_CUT_MAG = 31'h42CF_F1B4;
	localparam logic [30:0] INF_CUT_MAG  = 31'h42B1_7217;

	localparam logic signed [8:0] EXP_MIN_E = -9'sd126;
	localparam logic signed [8:0] EXP_MAX_E = 9'sd127;

	localparam logic [31:0] POW2_FRAC [16] = '{
		32'h3F80_0000, 32'h3F85_AAC3, 32'h3F8B_95C2, 32'h3F91_C3D3,
		32'h3F98_37F0, 32'h3F9E_F532, 32'h3FA5_FED7, 32'h3FAD_583F,
		32'h3FB5_04F3, 32'h3FBD_08A4, 32'h3FC5_672A, 32'h3FCE_248C,
		32'h3FD7_44FD, 32'h3FE0_CCDF, 32'h3FEA_C0C7, 32'h3FF5_257D
	};

	// significand with hidden bit
	function automatic logic [23:0] mant_of(input logic [31:0] f);
		return {f[30:23] != 8'd0, f[22:0]};
	endfunction

	// exponent of the significand's lsb
	function automatic logic signed [10:0] lsb_exp_of(input logic [31:0] f);
		logic signed [10:0] e;
		e = (f[30:23] == 8'd0) ? 11'sd1 : signed'({3'b000, f[30:23]});
		return e - 11'sd150;
	endfunction

	// right shift, lost bits or'ed into bit 0
	function automatic logic [79:0] shr_jam(input logic [79:0] v, input logic [6:0] sh);
		logic [79:0] o;
		logic [79:0] mask;
		if (sh >= 7'd80) begin
			o = {79'b0, |v};
		end else begin
			mask = ~({80{1'b1}} << sh);
			o = v >> sh;
			o[0] = o[0] | (|(v & mask));
		end
		return o;
	endfunction

	function automatic logic [6:0] msb_of(input logic [79:0] v);
		logic [6:0] p;
		p = '0;
		for (int i = 0; i < 80; i++) begin
			if (v[i]) p = 7'(i);
		end
		return p;
	endfunction

endpackage

### rtl/fexp_fma.sv
// ----------------------------------------------------------------------------
// fexp_fma
// four-stage fused multiply-add, a*b+c, one round to nearest even
// ----------------------------------------------------------------------------
module fexp_fma (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [31:0]     a,
	input  logic [31:0]     b,
	input  logic [31:0]     c,
	input  fexp_pkg::side_t side_in,
	output logic            out_valid,
	output logic [31:0]     r,
	output fexp_pkg::side_t side_out
);
	import fexp_pkg::*;

	logic               v_s1, v_s2, v_s3, v_s4;
	side_t              sd_s1, sd_s2, sd_s3, sd_s4;

	logic               ps_s1, cs_s1;
	logic [47:0]        pm_s1;
	logic [23:0]        cm_s1;
	logic signed [10:0] ep_s1, ec_s1;

	logic               sg_s2;
	logic [79:0]        m_s2;
	logic signed [10:0] wl_s2;

	logic               sg_s3, mz_s3;
	logic [79:0]        m_s3;
	logic signed [7:0]  r_s3;
	logic [9:0]         be_s3;

	logic [31:0]        r_s4;

	// stage 2 alignment and add
	logic               pz, cz, selc, bs, ss, sg_b;
	logic signed [10:0] ptop, ctop, gap, top;
	logic [6:0]         sh;
	logic [79:0]        pw, cw, big, small_op, m_b;
	logic [80:0]        d;

	always_comb begin
		ptop = ep_s1 + 11'sd47;
		ctop = ec_s1 + 11'sd23;
		pz = (pm_s1 == '0);
		cz = (cm_s1 == '0);
		selc = pz || (!cz && (ctop > ptop));
		gap = selc ? (ctop - ptop) : (ptop - ctop);
		if (gap < 0) sh = '0;
		else if (gap > 11'sd80) sh = 7'd80;
		else sh = 7'(gap);
		pw = {2'b00, pm_s1, 30'b0};
		cw = {2'b00, cm_s1, 54'b0};
		big = selc ? cw : pw;
		small_op = shr_jam(selc ? pw : cw, sh);
		bs = selc ? cs_s1 : ps_s1;
		ss = selc ? ps_s1 : cs_s1;
		top = selc ? ctop : ptop;
		d = {1'b0, big} - {1'b0, small_op};
		if (bs == ss) begin
			m_b = big + small_op;
			sg_b = bs;
		end else if (d[80]) begin
			m_b = 80'(-d);
			sg_b = ss;
		end else begin
			m_b = d[79:0];
			sg_b = bs;
		end
		// exact zero: negative only when both terms are negative
		if (m_b == '0) sg_b = ps_s1 & cs_s1;
	end

	// stage 3 leading one and rounding position
	logic [6:0]         msb;
	logic signed [10:0] e_c, rn, rs, rr;
	logic               sub;

	always_comb begin
		msb = msb_of(m_s2);
		e_c = signed'({4'b0, msb}) + wl_s2;
		rn = signed'({4'b0, msb}) - 11'sd23;
		rs = -11'sd149 - wl_s2;
		sub = rs > rn;
		rr = sub ? rs : rn;
	end

	// stage 4 shift and round
	logic [81:0] mx;
	logic [81:0] lowmask;
	logic [6:0]  ru;
	logic [23:0] mant;
	logic        g, st, rnd;
	logic [32:0] sum;
	logic [31:0] res_d;

	always_comb begin
		mx = {2'b00, m_s3};
		ru = r_s3[6:0];
		lowmask = '0;
		g = 1'b0;
		st = 1'b0;
		if (r_s3[7]) begin
			mant = 24'(m_s3 << 7'(-r_s3));
		end else begin
			mant = 24'(mx >> ru);
			if (ru != 7'd0) g = mx[ru - 7'd1];
			if (ru > 7'd1) begin
				lowmask = (82'd1 << (ru - 7'd1)) - 82'd1;
				st = |(mx & lowmask);
			end
		end
		rnd = g & (st | mant[0]);
		sum = {be_s3, 23'b0} + {9'b0, mant} + {32'b0, rnd};
		if (mz_s3) res_d = {sg_s3, 31'b0};
		else if (sum[32:23] >= 10'd255) res_d = {sg_s3, FP_INF[30:0]};
		else res_d = {sg_s3, sum[30:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ps_s1 <= a[31] ^ b[31];
			pm_s1 <= mant_of(a) * mant_of(b);
			ep_s1 <= lsb_exp_of(a) + lsb_exp_of(b);
			cs_s1 <= c[31];
			cm_s1 <= mant_of(c);
			ec_s1 <= lsb_exp_of(c);
			sd_s1 <= side_in;

			sg_s2 <= sg_b;
			m_s2 <= m_b;
			wl_s2 <= top - 11'sd77;
			sd_s2 <= sd_s1;

			sg_s3 <= sg_s2;
			m_s3 <= m_s2;
			mz_s3 <= (m_s2 == '0);
			r_s3 <= (rr > 11'sd81) ? 8'sd81 : 8'(rr);
			be_s3 <= sub ? 10'd0 : 10'(e_c + 11'sd126);
			sd_s3 <= sd_s2;

			r_s4 <= res_d;
			sd_s4 <= sd_s3;
		end
	end

	assign out_valid = v_s4;
	assign r = r_s4;
	assign side_out = sd_s4;

endmodule

### rtl/float32_exp_table_poly.sv
// ----------------------------------------------------------------------------
// float32_exp_table_poly
// single-precision exp(x) through a 16-entry table and a cubic polynomial
// ----------------------------------------------------------------------------
// Input channel item/item_valid/item_stall carries x_bits and last_in; the
// output channel result/result_valid/result_stall carries result_bits and
// last_out. An item moves at an edge with valid high and stall low.
// Ten fused multiply-add units of four register stages each, followed by one
// output register. One item is taken every cycle while result_stall does not
// stop the pipe; the rate is set by the fma pipeline.
// NaN inputs come back quiet, inputs below the zero cutoff give +0 and inputs
// above the infinity cutoff give +inf; last_out copies last_in.
// Reset clears the valid bits of every stage and of the output register.
// While the output holds an item and result_stall is high, the whole pipe
// stops and item_stall is raised; no item is dropped or repeated.
// ----------------------------------------------------------------------------
`include "float32_exp_table_poly_defines.svh"

module float32_exp_table_poly (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  fexp_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output fexp_pkg::result_t result
);
	import fexp_pkg::*;

	logic        adv;
	logic        vi  [NUM_FMA];
	logic        vld [NUM_FMA];
	logic [31:0] opa [NUM_FMA];
	logic [31:0] opb [NUM_FMA];
	logic [31:0] opc [NUM_FMA];
	logic [31:0] res [NUM_FMA];
	side_t       sdi [NUM_FMA];
	side_t       sd  [NUM_FMA];

	logic              out_valid_q;
	logic              sp_q;
	result_t           out_q;
	logic              is_nan, below, above;
	logic signed [8:0] e9, en9, eo9;

	assign adv = !(out_valid_q && result_stall);
	assign item_stall = !adv;

	always_comb begin
		is_nan = (item.x_bits[30:23] == 8'hFF) && (item.x_bits[22:0] != '0);
		below = item.x_bits[31] && (item.x_bits[30:0] > ZERO_CUT_MAG);
		above = !item.x_bits[31] && (item.x_bits[30:0] > INF_CUT_MAG);

		// scale exponents from n / 16, split so subnormal results come out right
		e9 = signed'(res[0][12:4]);
		if (e9 < EXP_MIN_E) en9 = EXP_MIN_E;
		else if (e9 > EXP_MAX_E) en9 = EXP_MAX_E;
		else en9 = e9;
		eo9 = e9 - en9;

		sdi[0] = '0;
		sdi[0].x = item.x_bits;
		sdi[0].sp = is_nan || below || above;
		sdi[0].spv = is_nan ? (item.x_bits | QUIET_BIT) : (above ? FP_INF : FP_ZERO);
		sdi[0].last = item.last_in;
		vi[0] = item_valid;
		opa[0] = item.x_bits;
		opb[0] = LOG2E_X16;
		opc[0] = MAGIC_BIAS;

		for (int i = 1; i < NUM_FMA; i++) begin
			vi[i] = vld[i - 1];
			sdi[i] = sd[i - 1];
		end

		// n back as a float
		sdi[1].l = POW2_FRAC[res[0][3:0]];
		sdi[1].sn = {9'(en9 + EXP_MAX_E), 23'b0};
		sdi[1].so = {9'(eo9 + EXP_MAX_E), 23'b0};
		opa[1] = res[0];
		opb[1] = FP_ONE;
		opc[1] = NEG_MAGIC;

		// cody-waite reduction
		sdi[2].v = res[1];
		opa[2] = res[1];
		opb[2] = LN2_O16_HI;
		opc[2] = sd[1].x;

		opa[3] = sd[2].v;
		opb[3] = LN2_O16_LO;
		opc[3] = res[2];

		// polynomial
		sdi[4].t = res[3];
		opa[4] = res[3];
		opb[4] = POLY_C3;
		opc[4] = POLY_C2;

		opa[5] = res[4];
		opb[5] = sd[4].t;
		opc[5] = FP_ZERO;

		opa[6] = sd[5].t;
		opb[6] = res[5];
		opc[6] = sd[5].t;

		opa[7] = sd[6].l;
		opb[7] = res[6];
		opc[7] = sd[6].l;

		// two-step scaling
		opa[8] = res[7];
		opb[8] = sd[7].sn;
		opc[8] = FP_ZERO;

		opa[9] = sd[8].so;
		opb[9] = res[8];
		opc[9] = FP_ZERO;
	end

	for (genvar gi = 0; gi < NUM_FMA; gi++) begin : g_fma
		fexp_fma u_fma (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.in_valid (vi[gi]),
			.a        (opa[gi]),
			.b        (opb[gi]),
			.c        (opc[gi]),
			.side_in  (sdi[gi]),
			.out_valid(vld[gi]),
			.r        (res[gi]),
			.side_out (sd[gi])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld[NUM_FMA - 1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sp_q <= sd[NUM_FMA - 1].sp;
			out_q.result_bits <= sd[NUM_FMA - 1].sp ? sd[NUM_FMA - 1].spv : res[NUM_FMA - 1];
			out_q.last_out <= sd[NUM_FMA - 1].last;
		end
	end

	assign result_valid = out_valid_q;
	assign result = out_q;

	`FEXP_ASSERT(a_tail_holds, vld[NUM_FMA - 1] && !adv |=> vld[NUM_FMA - 1], "tail item lost in stall")
	`FEXP_ASSERT(a_out_from_tail, $rose(result_valid) |-> $past(vld[NUM_FMA - 1]), "output item without tail item")
	`FEXP_ASSERT(a_exp_positive, result_valid && !sp_q |-> !result.result_bits[31], "negative exponential")
	`FEXP_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !result_valid, "output valid in reset")

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks float32_exp_table_poly against a bit-true exp predictor.
// The predictor does each fused multiply-add in double precision, rounds to
// odd and then to single. Directed edge values run first, then random items.
// The sender and the receiver idle at random, and there is one long output
// hold and one full drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
	import fexp_pkg::*;

	localparam int N_RANDOM = 630;

	localparam logic [31:0] C_MAGIC    = 32'h4B40_0000;
	localparam logic [31:0] C_NMAGIC   = 32'hCB40_0000;
	localparam logic [31:0] C_LOG2E16  = 32'h41B8_AA3B;
	localparam logic [31:0] C_LN2HI    = 32'hBD31_7218;
	localparam logic [31:0] C_LN2LO    = 32'h2F02_E308;
	localparam logic [31:0] C_C2       = 32'h3F00_010F;
	localparam logic [31:0] C_C3       = 32'h3E2A_AACD;
	localparam logic [31:0] C_ONE      = 32'h3F80_0000;
	localparam logic [31:0] C_ZERO     = 32'h0000_0000;
	localparam logic [31:0] C_PINF     = 32'h7F80_0000;
	localparam logic [31:0] C_ZCUT     = 32'hC2CF_F1B4;
	localparam logic [31:0] C_ICUT     = 32'h42B1_7217;
	localparam logic [31:0] C_EMIN     = 32'hC100_0000;
	localparam logic [31:0] C_EMAX     = 32'h3F80_0000;
	localparam logic [31:0] C_EFIELD   = 32'h007F_FFF0;

	localparam logic [31:0] FRAC_TAB [16] = '{
		32'h3F80_0000, 32'h3F85_AAC3, 32'h3F8B_95C2, 32'h3F91_C3D3,
		32'h3F98_37F0, 32'h3F9E_F532, 32'h3FA5_FED7, 32'h3FAD_583F,
		32'h3FB5_04F3, 32'h3FBD_08A4, 32'h3FC5_672A, 32'h3FCE_248C,
		32'h3FD7_44FD, 32'h3FE0_CCDF, 32'h3FEA_C0C7, 32'h3FF5_257D
	};

	logic clk;
	logic arst_n = 1'b1;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;

	item_t pend_q[$];
	result_t exp_q[$];
	int n_acc = 0;
	int errors = 0;
	logic hold_rx = 1'b0;
	logic pause_tx = 1'b0;

	float32_exp_table_poly dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic real to_double(input logic [31:0] f);
		real r;
		if (f[30:23] == 8'hFF) begin
			return $bitstoreal({f[31], 11'h7FF, f[22:0], 29'b0});
		end
		if (f[30:23] == 8'd0) begin
			r = real'(int'(f[22:0])) * $bitstoreal(64'(1023 - 149) << 52);
			return f[31] ? -r : r;
		end
		return $bitstoreal({f[31], {3'b000, f[30:23]} + 11'd896, f[22:0], 29'b0});
	endfunction

	// double to single, round to nearest even, subnormals kept
	function automatic logic [31:0] to_single(input real r);
		logic [63:0] d;
		logic [63:0] sig;
		logic [63:0] kept;
		logic [63:0] rem;
		logic [63:0] half;
		int fe;
		int sh;
		d = $realtobits(r);
		if (d[62:52] == 11'd0) return {d[63], 31'b0};
		if (d[62:52] == 11'h7FF) return {d[63], 8'hFF, 23'b0};
		fe = int'(d[62:52]) - 1023 + 127;
		sig = {11'b0, 1'b1, d[51:0]};
		sh = (fe >= 1) ? 29 : 30 - fe;
		if (sh > 60) return {d[63], 31'b0};
		kept = sig >> sh;
		rem = sig & ((64'd1 << sh) - 64'd1);
		half = 64'd1 << (sh - 1);
		if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
		if (fe >= 1) begin
			if (kept[24]) begin
				kept = kept >> 1;
				fe = fe + 1;
			end
			if (fe >= 255) return {d[63], 8'hFF, 23'b0};
			return {d[63], 8'(fe), kept[22:0]};
		end
		return {d[63], kept[30:0]};
	endfunction

	// a*b+c rounded once: exact product, two-sum, round to odd, then to single
	function automatic logic [31:0] fma32(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c);
		real p;
		real cd;
		real s;
		real bp;
		real bc;
		real err;
		logic [63:0] u;
		p = to_double(a) * to_double(b);
		cd = to_double(c);
		s = p + cd;
		bp = s - cd;
		bc = s - bp;
		err = (p - bp) + (cd - bc);
		if (err != 0.0) begin
			u = $realtobits(s);
			if (!u[0]) begin
				if ((s > 0.0) == (err > 0.0)) u = u + 64'd1;
				else u = u - 64'd1;
				s = $bitstoreal(u);
			end
		end
		return to_single(s);
	endfunction

	function automatic logic [31:0] exp_of(input logic [31:0] x);
		logic [31:0] v;
		logic [31:0] nb;
		logic [31:0] eo;
		logic [31:0] en;
		logic [31:0] sn;
		logic [31:0] so;
		logic [31:0] l;
		logic [31:0] t;
		logic [31:0] p;
		logic [31:0] f;
		if (x[30:23] == 8'hFF && x[22:0] != 23'd0) return x | 32'h0040_0000;
		if (to_double(x) < to_double(C_ZCUT)) return C_ZERO;
		if (to_double(x) > to_double(C_ICUT)) return C_PINF;
		v = fma32(x, C_LOG2E16, C_MAGIC);
		nb = v;
		eo = (nb & C_EFIELD) << 19;
		en = ($signed(eo) < $signed(C_EMIN)) ? C_EMIN : eo;
		en = ($signed(C_EMAX) < $signed(en)) ? C_EMAX : en;
		eo = eo - en;
		sn = en + C_EMAX;
		so = eo + C_EMAX;
		l = FRAC_TAB[nb[3:0]];
		v = fma32(v, C_ONE, C_NMAGIC);
		t = fma32(v, C_LN2HI, x);
		t = fma32(v, C_LN2LO, t);
		p = fma32(t, C_C3, C_C2);
		p = fma32(p, t, C_ZERO);
		p = fma32(t, p, t);
		f = fma32(l, p, l);
		f = fma32(f, sn, C_ZERO);
		f = fma32(so, f, C_ZERO);
		return f;
	endfunction

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $time, what);
		errors++;
	endtask

	function automatic int tx_idle_pct();
		if (n_acc < 220) return 22;
		if (n_acc < 440) return 60;
		return 0;
	endfunction

	function automatic int rx_idle_pct();
		if (n_acc < 220) return 60;
		if (n_acc < 440) return 22;
		return 0;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				exp_q.push_back('{result_bits: exp_of(item.x_bits), last_out: item.last_in});
				n_acc <= n_acc + 1;
			end
			if (!item_valid || !item_stall) begin
				if (pause_tx || pend_q.size() == 0 || $urandom_range(99) < tx_idle_pct()) begin
					item_valid <= 1'b0;
				end else begin
					item_valid <= 1'b1;
					item <= pend_q.pop_front();
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (exp_q.size() == 0) begin
					report($sformatf("unexpected item %h", result));
				end else begin
					want = exp_q.pop_front();
					if (result.result_bits !== want.result_bits)
						report($sformatf("result_bits %h, want %h", result.result_bits,
							want.result_bits));
					if (result.last_out !== want.last_out)
						report($sformatf("last_out %b, want %b", result.last_out, want.last_out));
				end
			end
			result_stall <= hold_rx || ($urandom_range(99) < rx_idle_pct());
		end
	end

	// long output hold while the sender keeps offering
	initial begin
		wait (n_acc >= 300);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (120) @(posedge clk);
		hold_rx <= 1'b0;
	end

	// sender pause until the pipe drains
	initial begin
		wait (n_acc >= 500);
		@(posedge clk);
		pause_tx <= 1'b1;
		wait (exp_q.size() == 0 && !item_valid);
		@(posedge clk);
		pause_tx <= 1'b0;
	end

	initial begin
		#2ms;
		$display("status: fail");
		$finish;
	end

	initial begin
		logic [31:0] dir [$];
		logic [31:0] xb;
		real rv;
		dir = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
			32'h0000_0001, 32'h807F_FFFF, 32'h7F80_0000, 32'hFF80_0000,
			32'h7FC0_0000, 32'h7F80_0001, 32'hFFBF_FFFF, 32'h7F7F_FFFF,
			32'hFF7F_FFFF, C_ZCUT, C_ZCUT + 32'd1, C_ZCUT - 32'd1,
			C_ICUT, C_ICUT + 32'd1, C_ICUT - 32'd1, 32'hC2AE_0000,
			32'hC2BA_0000, 32'h3F31_7218, 32'h4120_0000, 32'hC2C8_0000};
		foreach (dir[i]) pend_q.push_back('{x_bits: dir[i], last_in: i[0]});
		for (int i = 0; i < N_RANDOM; i++) begin
			case ($urandom_range(9))
				0, 1: xb = $urandom;
				2: xb = ($urandom_range(1) ? C_ZCUT : C_ICUT) + 32'($urandom_range(64)) - 32'd32;
				3: xb = {$urandom_range(1) == 1, 8'($urandom_range(140, 100)), 23'($urandom)};
				default: begin
					rv = -104.0 + 193.0 * (real'($urandom) / 4294967296.0);
					xb = to_single(rv);
				end
			endcase
			pend_q.push_back('{x_bits: xb, last_in: ($urandom_range(15) == 0)});
		end
		// a real falling edge on reset so every valid bit starts cleared
		#1;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (pend_q.size() == 0);
		@(posedge clk);
		while (item_valid) @(posedge clk);
		wait (exp_q.size() == 0);
		repeat (60) @(posedge clk);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
